/* design/cpvc_pkg.sv */
// shared types, constants and saturation helpers for the cascaded controller
`timescale 1ns / 1ps
package cpvc_pkg;

    localparam logic signed [31:0] GRAVITY_Q      = 32'sd642908;
    localparam logic signed [31:0] INTEGRAL_LIMIT = 32'sd327680;
    localparam logic signed [31:0] S32_MAX        = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN        = 32'sh80000000;

    // configuration register indexes
    localparam logic [2:0] REG_POS_H_GAIN  = 3'd0;
    localparam logic [2:0] REG_POS_V_GAIN  = 3'd1;
    localparam logic [2:0] REG_POS_H_LIMIT = 3'd2;
    localparam logic [2:0] REG_POS_V_LIMIT = 3'd3;
    localparam logic [2:0] REG_VEL_H_GAIN  = 3'd4;
    localparam logic [2:0] REG_VEL_V_GAIN  = 3'd5;
    localparam logic [2:0] REG_INT_H_GAIN  = 3'd6;
    localparam logic [2:0] REG_INT_V_GAIN  = 3'd7;

    // request kinds carried in tuser
    localparam logic ACT_SETPOINT = 1'b0;
    localparam logic ACT_STEP     = 1'b1;

    typedef enum logic [1:0] {
        IT_SQRT,
        IT_DIV
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADV_MUL,
        ST_ADV_ACC,
        ST_POS_MUL,
        ST_POS_ACC,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_SC_MUL,
        ST_SC_DIV,
        ST_SC_WAIT,
        ST_VCAP,
        ST_VP_MUL,
        ST_VP_ACC,
        ST_VI_MUL,
        ST_VI_ACC,
        ST_VD_MUL,
        ST_VD_ACC,
        ST_FIN
    } state_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 34'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(34'(a) - 34'(b));
    endfunction

    // Q16.16 product: floor shift by 16, then saturate
    function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
        logic signed [65:0] s;
        logic signed [31:0] r;
        s = p >>> 16;
        if (s > 66'(S32_MAX)) begin
            r = S32_MAX;
        end else if (s < 66'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

/* design/cpvc_mul.sv */
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module cpvc_mul
    import cpvc_pkg::*;
(
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    // one product per cycle, used the cycle after issue
    always_ff @(posedge aclk) begin
        prod_reg <= 66'(op_a) * 66'(op_b);
    end

    assign prod = prod_reg;

endmodule

/* design/cpvc_iter.sv */
// bit-serial square root and divider sharing one remainder datapath
`timescale 1ns / 1ps
module cpvc_iter
    import cpvc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  iter_ctl_t   ctl,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] result
);

    logic [35:0] rem_reg, rem_next;
    logic [63:0] src_reg, src_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    iter_op_t    op_reg;

    logic [35:0] rem_s, trial_s, rem_d, trial_d;

    // one root digit or one quotient bit per cycle
    always_comb begin
        rem_s   = {rem_reg[33:0], src_reg[63:62]};
        trial_s = {2'b00, res_reg, 2'b01};
        rem_d   = {rem_reg[34:0], src_reg[63]};
        trial_d = {4'b0000, den_reg};
        rem_next = rem_reg;
        src_next = src_reg;
        res_next = res_reg;
        case (op_reg)
            IT_SQRT: begin
                src_next = {src_reg[61:0], 2'b00};
                if (rem_s >= trial_s) begin
                    rem_next = rem_s - trial_s;
                    res_next = {res_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_s;
                    res_next = {res_reg[30:0], 1'b0};
                end
            end
            IT_DIV: begin
                src_next = {src_reg[62:0], 1'b0};
                if (rem_d >= trial_d) begin
                    rem_next = rem_d - trial_d;
                    res_next = {res_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_d;
                    res_next = {res_reg[30:0], 1'b0};
                end
            end
            default: begin
                rem_next = rem_reg;
            end
        endcase
    end

    // control: 32 steps after start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath load and step
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            op_reg  <= ctl.op;
            den_reg <= den;
            res_reg <= '0;
            if (ctl.op == IT_DIV) begin
                rem_reg <= {4'b0000, num[63:32]};
                src_reg <= {num[31:0], 32'b0};
            end else begin
                rem_reg <= '0;
                src_reg <= num;
            end
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            src_reg <= src_next;
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* design/cascaded_position_velocity_controller_unit.sv */
// top level: sequencer, state and registers of the cascaded controller
//
// Three-axis cascaded P position / PI velocity controller in signed Q16.16.
// Input channel s_*: tuser carries the action (0 loads a setpoint, 1 runs a
// control step with a measurement); tdata carries positions, velocities,
// delta_time and control_enable. Result channel m_*: one request with the
// three accelerations for every control step, none for a setpoint load.
// Configuration port cfg_*: register index and data, always ready.
// A control step with a fresh setpoint skips the setpoint advance. Scaling
// the horizontal vector adds two divisions. One shared multiplier is issued
// once per operation; the square root and each of the two divisions walk a
// bit-serial unit for 32 steps.
// s_tready is low while a step runs. A finished result sits in an output
// register; if the receiver stalls with a result still pending, the next
// step waits at its end until that register is free.
// Reset clears the setpoint, the integrals, the fresh flag and the output
// register's valid flag, and loads default gains and limits.
`timescale 1ns / 1ps
module cascaded_position_velocity_controller_unit
    import cpvc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, delta_time, control_enable
    input  logic [215:0] s_tdata,
    // action
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_x, accel_y, accel_z
    output logic [95:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    state_t state_reg, state_next;
    logic [1:0] idx_reg;

    logic [30:0]        pos_h_gain_reg, pos_v_gain_reg, pos_h_limit_reg;
    logic signed [31:0] pos_v_limit_reg;
    logic [30:0]        vel_h_gain_reg, vel_v_gain_reg, int_h_gain_reg, int_v_gain_reg;

    logic signed [31:0] tp_reg [3];
    logic signed [31:0] tv_reg [3];
    logic signed [31:0] integ_reg [3];
    logic signed [31:0] mp_reg [3];
    logic signed [31:0] mv_reg [3];
    logic signed [31:0] pc_reg [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] t_reg;
    logic [15:0]        dt_reg;
    logic               en_reg;
    logic               fresh_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        len_reg;
    logic [95:0]        out_reg;
    logic               out_valid_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic signed [31:0] qs, ve, iv;
    logic signed [31:0] out_x, out_y, out_z;
    logic               in_acc, out_free;
    iter_ctl_t          it_ctl;
    logic [63:0]        it_num;
    logic               it_done;
    logic [31:0]        it_res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    cpvc_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    cpvc_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (it_ctl),
        .num     (it_num),
        .den     (len_reg),
        .done    (it_done),
        .result  (it_res)
    );

    // velocity error of the current axis and product helpers
    assign qs = qsat(prod);
    assign ve = sub_sat(add_sat(pc_reg[idx_reg], tv_reg[idx_reg]), mv_reg[idx_reg]);

    // integral update with enable and clamp
    always_comb begin
        iv = add_sat(integ_reg[idx_reg], qs);
        if (!en_reg) begin
            iv = '0;
        end
        if (iv > INTEGRAL_LIMIT) begin
            iv = INTEGRAL_LIMIT;
        end else if (iv < -INTEGRAL_LIMIT) begin
            iv = -INTEGRAL_LIMIT;
        end
    end

    // final sums
    assign out_x = add_sat(acc_reg[0], integ_reg[0]);
    assign out_y = add_sat(acc_reg[1], integ_reg[1]);
    assign out_z = add_sat(add_sat(acc_reg[2], GRAVITY_Q), integ_reg[2]);

    // multiplier operand selection
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_ADV_MUL: begin
                op_a = 33'(tv_reg[idx_reg]);
                op_b = {17'b0, dt_reg};
            end
            ST_POS_MUL: begin
                op_a = 33'(sub_sat(tp_reg[idx_reg], mp_reg[idx_reg]));
                op_b = {2'b00, (idx_reg == 2'd2) ? pos_v_gain_reg : pos_h_gain_reg};
            end
            ST_SQ_MUL: begin
                op_a = 33'(pc_reg[idx_reg]);
                op_b = 33'(pc_reg[idx_reg]);
            end
            ST_SC_MUL: begin
                op_a = pc_reg[idx_reg][31] ? -33'(pc_reg[idx_reg]) : 33'(pc_reg[idx_reg]);
                op_b = {2'b00, pos_h_limit_reg};
            end
            ST_VP_MUL: begin
                op_a = 33'(ve);
                op_b = {2'b00, (idx_reg == 2'd2) ? vel_v_gain_reg : vel_h_gain_reg};
            end
            ST_VI_MUL: begin
                op_a = 33'(ve);
                op_b = {2'b00, (idx_reg == 2'd2) ? int_v_gain_reg : int_h_gain_reg};
            end
            ST_VD_MUL: begin
                op_a = 33'(t_reg);
                op_b = {17'b0, dt_reg};
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    // next state and iterative unit control
    always_comb begin
        state_next = state_reg;
        it_ctl     = '{start: 1'b0, op: IT_SQRT};
        it_num     = sq_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser[0] == ACT_STEP) begin
                    state_next = fresh_reg ? ST_POS_MUL : ST_ADV_MUL;
                end
            end
            ST_ADV_MUL: state_next = ST_ADV_ACC;
            ST_ADV_ACC: state_next = (idx_reg == 2'd2) ? ST_POS_MUL : ST_ADV_MUL;
            ST_POS_MUL: state_next = ST_POS_ACC;
            ST_POS_ACC: state_next = (idx_reg == 2'd2) ? ST_SQ_MUL : ST_POS_MUL;
            ST_SQ_MUL:  state_next = ST_SQ_ACC;
            ST_SQ_ACC:  state_next = (idx_reg == 2'd1) ? ST_SQRT_GO : ST_SQ_MUL;
            ST_SQRT_GO: begin
                it_ctl     = '{start: 1'b1, op: IT_SQRT};
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (it_done) begin
                    state_next = (it_res > {1'b0, pos_h_limit_reg}) ? ST_SC_MUL : ST_VCAP;
                end
            end
            ST_SC_MUL: state_next = ST_SC_DIV;
            ST_SC_DIV: begin
                it_ctl     = '{start: 1'b1, op: IT_DIV};
                it_num     = prod[63:0];
                state_next = ST_SC_WAIT;
            end
            ST_SC_WAIT: begin
                if (it_done) begin
                    state_next = (idx_reg == 2'd1) ? ST_VCAP : ST_SC_MUL;
                end
            end
            ST_VCAP:   state_next = ST_VP_MUL;
            ST_VP_MUL: state_next = ST_VP_ACC;
            ST_VP_ACC: state_next = ST_VI_MUL;
            ST_VI_MUL: state_next = ST_VI_ACC;
            ST_VI_ACC: state_next = ST_VD_MUL;
            ST_VD_MUL: state_next = ST_VD_ACC;
            ST_VD_ACC: state_next = (idx_reg == 2'd2) ? ST_FIN : ST_VP_MUL;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_h_gain_reg  <= 31'd65536;
            pos_v_gain_reg  <= 31'd65536;
            pos_h_limit_reg <= 31'd131072;
            pos_v_limit_reg <= 32'sd65536;
            vel_h_gain_reg  <= 31'd65536;
            vel_v_gain_reg  <= 31'd65536;
            int_h_gain_reg  <= '0;
            int_v_gain_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_POS_H_GAIN:  pos_h_gain_reg  <= cfg_data[30:0];
                REG_POS_V_GAIN:  pos_v_gain_reg  <= cfg_data[30:0];
                REG_POS_H_LIMIT: pos_h_limit_reg <= cfg_data[30:0];
                REG_POS_V_LIMIT: pos_v_limit_reg <= cfg_data;
                REG_VEL_H_GAIN:  vel_h_gain_reg  <= cfg_data[30:0];
                REG_VEL_V_GAIN:  vel_v_gain_reg  <= cfg_data[30:0];
                REG_INT_H_GAIN:  int_h_gain_reg  <= cfg_data[30:0];
                REG_INT_V_GAIN:  int_v_gain_reg  <= cfg_data[30:0];
                default:         pos_h_gain_reg  <= pos_h_gain_reg;
            endcase
        end
    end

    // controller state: setpoint, integrals, fresh flag, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                tp_reg[i]    <= '0;
                tv_reg[i]    <= '0;
                integ_reg[i] <= '0;
            end
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            // output register fills at the end of a step, empties on handshake
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (in_acc && s_tuser[0] == ACT_SETPOINT) begin
                        for (int i = 0; i < 3; i++) begin
                            tp_reg[i] <= s_tdata[32*i +: 32];
                            tv_reg[i] <= s_tdata[96 + 32*i +: 32];
                        end
                        fresh_reg <= 1'b1;
                    end else if (in_acc) begin
                        fresh_reg <= 1'b0;
                    end
                end
                ST_ADV_ACC: begin
                    tp_reg[idx_reg] <= add_sat(tp_reg[idx_reg], qs);
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
                ST_POS_ACC: begin
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
                ST_SQ_ACC: begin
                    idx_reg <= (idx_reg == 2'd1) ? 2'd0 : idx_reg + 2'd1;
                end
                ST_SC_WAIT: begin
                    if (it_done) begin
                        idx_reg <= (idx_reg == 2'd1) ? 2'd0 : idx_reg + 2'd1;
                    end
                end
                ST_VCAP: begin
                    idx_reg <= '0;
                end
                ST_VD_ACC: begin
                    integ_reg[idx_reg] <= iv;
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
                default: begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // working registers of one control step
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    for (int i = 0; i < 3; i++) begin
                        mp_reg[i] <= s_tdata[32*i +: 32];
                        mv_reg[i] <= s_tdata[96 + 32*i +: 32];
                    end
                    dt_reg <= s_tdata[207:192];
                    en_reg <= s_tdata[208];
                end
            end
            ST_POS_ACC: pc_reg[idx_reg] <= qs;
            ST_SQ_ACC: begin
                sq_reg <= (idx_reg == 2'd0) ? prod[63:0] : sq_reg + prod[63:0];
            end
            ST_SQRT_WAIT: begin
                if (it_done) begin
                    len_reg <= it_res;
                end
            end
            ST_SC_WAIT: begin
                if (it_done) begin
                    pc_reg[idx_reg] <= pc_reg[idx_reg][31] ? -it_res : it_res;
                end
            end
            ST_VCAP: begin
                if (pc_reg[2] > pos_v_limit_reg) begin
                    pc_reg[2] <= pos_v_limit_reg;
                end
            end
            ST_VP_ACC: acc_reg[idx_reg] <= qs;
            ST_VI_ACC: t_reg <= qs;
            ST_FIN: begin
                if (out_free) begin
                    out_reg <= {out_z, out_y, out_x};
                end
            end
            default: begin
                t_reg <= t_reg;
            end
        endcase
    end

    // checks on the sequencer and the integrator
    assert property (@(posedge aclk) disable iff (!aresetn)
        it_done |-> (state_reg == ST_SQRT_WAIT || state_reg == ST_SC_WAIT))
        else $error("iterative unit finished outside a wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tuser[0] == ACT_SETPOINT) |=> fresh_reg)
        else $error("setpoint load did not mark the setpoint fresh");

    assert property (@(posedge aclk) disable iff (!aresetn)
        integ_reg[0] <= INTEGRAL_LIMIT && integ_reg[0] >= -INTEGRAL_LIMIT &&
        integ_reg[2] <= INTEGRAL_LIMIT && integ_reg[2] >= -INTEGRAL_LIMIT)
        else $error("integral outside its clamp");

    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd3)
        else $error("axis index out of range");

endmodule

/* dv/tb.sv */
// self-checking testbench for the cascaded position/velocity controller
`timescale 1ns / 1ps
module tb;
    import cpvc_pkg::*;

    // stimulus request: action in tuser, measurement or setpoint in tdata
    typedef struct {
        logic              act;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic [15:0]       dt;
        logic              en;
    } ctl_req_t;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] val;
    } reg_wr_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [215:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    cascaded_position_velocity_controller_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of registers and state
    logic [30:0]        g_pos_h, g_pos_v, lim_h, g_vel_h, g_vel_v, g_int_h, g_int_v;
    logic signed [31:0] lim_v;
    logic signed [31:0] sp_pos [3];
    logic signed [31:0] sp_vel [3];
    logic               sp_fresh;
    logic signed [31:0] integ [3];

    ctl_req_t     pending_reqs [$];
    reg_wr_t      pending_regs [$];
    logic [95:0]  accel_expected [$];
    int           errors = 0;
    int           mismatches = 0;
    int           results_seen = 0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // q16.16 product, floor, saturated; operands fit in 33 bits each
    function automatic logic signed [31:0] qprod(input longint a, input longint b);
        logic signed [127:0] p;
        logic signed [127:0] s;
        p = 128'(a) * 128'(b);
        s = p >>> 16;
        if (s > 128'sd2147483647) return 32'sh7fffffff;
        if (s < -128'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] shrink(input logic signed [31:0] c,
                                                  input longint unsigned lim,
                                                  input longint unsigned len);
        longint unsigned m, q;
        m = (c < 0) ? longint'(-longint'(c)) : longint'(c);
        q = (m * lim) / len;
        return (c < 0) ? 32'(-longint'(q)) : 32'(q);
    endfunction

    task automatic reset_model();
        g_pos_h = 31'd65536; g_pos_v = 31'd65536; lim_h = 31'd131072;
        lim_v = 32'sd65536; g_vel_h = 31'd65536; g_vel_v = 31'd65536;
        g_int_h = '0; g_int_v = '0;
        sp_fresh = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sp_pos[i] = '0; sp_vel[i] = '0; integ[i] = '0;
        end
    endtask

    task automatic write_model_reg(input reg_wr_t w);
        case (w.idx)
            REG_POS_H_GAIN:  g_pos_h = w.val[30:0];
            REG_POS_V_GAIN:  g_pos_v = w.val[30:0];
            REG_POS_H_LIMIT: lim_h = w.val[30:0];
            REG_POS_V_LIMIT: lim_v = w.val;
            REG_VEL_H_GAIN:  g_vel_h = w.val[30:0];
            REG_VEL_V_GAIN:  g_vel_v = w.val[30:0];
            REG_INT_H_GAIN:  g_int_h = w.val[30:0];
            REG_INT_V_GAIN:  g_int_v = w.val[30:0];
            default: ;
        endcase
    endtask

    // store the setpoint of a setpoint load, or compute the acceleration command for a control step
    task automatic predict_accel(input ctl_req_t r);
        logic signed [31:0] pc [3];
        logic signed [31:0] acc [3];
        logic signed [31:0] cmd, ve, iv;
        longint unsigned    sq, len;
        longint             pg, ig;
        logic [95:0]        packed_acc;
        if (r.act == ACT_SETPOINT) begin
            for (int i = 0; i < 3; i++) begin
                sp_pos[i] = r.pos[i]; sp_vel[i] = r.vel[i];
            end
            sp_fresh = 1'b1;
            return;
        end
        if (sp_fresh) sp_fresh = 1'b0;
        else
            for (int i = 0; i < 3; i++)
                sp_pos[i] = clamp32(longint'(sp_pos[i]) + qprod(sp_vel[i], r.dt));
        for (int i = 0; i < 3; i++)
            pc[i] = qprod(clamp32(longint'(sp_pos[i]) - longint'(r.pos[i])),
                          (i < 2) ? longint'(g_pos_h) : longint'(g_pos_v));
        sq = longint'(pc[0]) * longint'(pc[0]) + longint'(pc[1]) * longint'(pc[1]);
        len = root64(sq);
        if (len > longint'(lim_h)) begin
            pc[0] = shrink(pc[0], lim_h, len);
            pc[1] = shrink(pc[1], lim_h, len);
        end
        if (pc[2] > lim_v) pc[2] = lim_v;
        for (int i = 0; i < 3; i++) begin
            pg = (i < 2) ? longint'(g_vel_h) : longint'(g_vel_v);
            ig = (i < 2) ? longint'(g_int_h) : longint'(g_int_v);
            cmd = clamp32(longint'(pc[i]) + longint'(sp_vel[i]));
            ve = clamp32(longint'(cmd) - longint'(r.vel[i]));
            acc[i] = qprod(ve, pg);
            iv = clamp32(longint'(integ[i]) + qprod(qprod(ve, ig), r.dt));
            if (!r.en) iv = '0;
            if (iv > INTEGRAL_LIMIT) iv = INTEGRAL_LIMIT;
            else if (iv < -INTEGRAL_LIMIT) iv = -INTEGRAL_LIMIT;
            integ[i] = iv;
        end
        acc[2] = clamp32(longint'(acc[2]) + longint'(GRAVITY_Q));
        for (int i = 0; i < 3; i++)
            packed_acc[32*i +: 32] = clamp32(longint'(acc[i]) + longint'(integ[i]));
        accel_expected.push_back(packed_acc);
    endtask

    function automatic logic signed [31:0] rand_s32();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 20 * 65536))) - 32'sd655360;
            3: return $signed(32'($urandom_range(0, 2000 * 65536))) - 32'sd65536000;
            default: return $urandom;
        endcase
    endfunction

    function automatic ctl_req_t rand_req(input logic act);
        ctl_req_t r;
        r.act = act;
        for (int i = 0; i < 3; i++) begin
            r.pos[i] = rand_s32();
            r.vel[i] = rand_s32();
        end
        case ($urandom_range(0, 3))
            0: r.dt = 16'hffff;
            1: r.dt = '0;
            default: r.dt = 16'($urandom);
        endcase
        r.en = ($urandom_range(0, 3) != 0);
        return r;
    endfunction

    function automatic ctl_req_t fixed_req(input logic act, input logic signed [31:0] p,
                                           input logic signed [31:0] v,
                                           input logic [15:0] dt, input logic en);
        ctl_req_t r;
        r.act = act;
        for (int i = 0; i < 3; i++) begin
            r.pos[i] = p; r.vel[i] = v;
        end
        r.dt = dt; r.en = en;
        return r;
    endfunction

    // input driver with random gaps
    int in_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_accel(pending_reqs.pop_front());
                s_tvalid <= 1'b0;
                in_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            end else if (!s_tvalid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_reqs.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_reqs[0].act;
                    s_tdata <= {7'b0, pending_reqs[0].en, pending_reqs[0].dt,
                                pending_reqs[0].vel[2], pending_reqs[0].vel[1],
                                pending_reqs[0].vel[0], pending_reqs[0].pos[2],
                                pending_reqs[0].pos[1], pending_reqs[0].pos[0]};
                end
            end
        end
    end

    // configuration writer, fed only while the block is idle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                write_model_reg(pending_regs.pop_front());
                cfg_valid <= 1'b0;
            end else if (!cfg_valid && pending_regs.size() > 0) begin
                cfg_valid <= 1'b1;
                cfg_index <= pending_regs[0].idx;
                cfg_data <= pending_regs[0].val;
            end
        end
    end

    // result monitor with random stalls
    int out_wait = 0;
    always @(posedge aclk) begin
        logic [95:0] exp_acc;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (accel_expected.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected result %h", m_tdata);
                end else begin
                    exp_acc = accel_expected.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (m_tdata[32*i +: 32] !== exp_acc[32*i +: 32]) begin
                            errors++;
                            if (mismatches++ < 10)
                                $display("accel axis %0d: expected %h got %h",
                                         i, exp_acc[32*i +: 32], m_tdata[32*i +: 32]);
                        end
                end
                out_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
                m_tready <= (out_wait == 0);
            end else if (out_wait > 0) begin
                out_wait--;
                m_tready <= (out_wait == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles = 0;
        else if (++idle_cycles >= 5000) begin
            $display("[cascaded_position_velocity_controller_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        reg_wr_t w;
        w.idx = idx; w.val = val;
        pending_regs.push_back(w);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || accel_expected.size() > 0
               || pending_regs.size() > 0 || cfg_valid)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_regs(input int mode);
        logic [31:0] big;
        logic [31:0] gain_4, lim_8;
        big = 32'h7fffffff;
        gain_4 = 32'($urandom_range(0, 4 << 16));
        write_reg(REG_POS_H_GAIN,  mode == 0 ? big : (mode == 1 ? 32'd0 : gain_4));
        gain_4 = 32'($urandom_range(0, 4 << 16));
        write_reg(REG_POS_V_GAIN,  mode == 0 ? big : (mode == 1 ? 32'd0 : gain_4));
        lim_8 = 32'($urandom_range(0, 8 << 16));
        write_reg(REG_POS_H_LIMIT, mode == 0 ? big : (mode == 1 ? 32'd0 : lim_8));
        write_reg(REG_POS_V_LIMIT, mode == 0 ? 32'h80000000 : (mode == 1 ? big : $urandom));
        write_reg(REG_VEL_H_GAIN,  mode == 0 ? big : (mode == 1 ? 32'd0 : $urandom));
        gain_4 = 32'($urandom_range(0, 4 << 16));
        write_reg(REG_VEL_V_GAIN,  mode == 0 ? big : (mode == 1 ? 32'd0 : gain_4));
        gain_4 = 32'($urandom_range(0, 4 << 16));
        write_reg(REG_INT_H_GAIN,  mode == 0 ? big : (mode == 1 ? 32'd0 : gain_4));
        write_reg(REG_INT_V_GAIN,  mode == 0 ? big : (mode == 1 ? 32'd0 : $urandom));
    endtask

    // stimulus: directed requests, then random phases with new settings
    initial begin
        reset_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // step with setpoint never loaded, then extremes and saturation
        pending_reqs.push_back(fixed_req(ACT_STEP, 32'sd65536, 32'sd0, 16'd100, 1'b1));
        pending_reqs.push_back(fixed_req(ACT_STEP, 32'sh7fffffff, 32'sh80000000, 16'hffff, 1'b1));
        pending_reqs.push_back(fixed_req(ACT_SETPOINT, 32'sh80000000, 32'sh7fffffff, 16'd0,
                                         1'b0));
        pending_reqs.push_back(fixed_req(ACT_STEP, 32'sh7fffffff, 32'sh80000000, 16'hffff, 1'b1));
        pending_reqs.push_back(fixed_req(ACT_STEP, 32'sh80000000, 32'sh7fffffff, 16'hffff, 1'b0));
        pending_reqs.push_back(fixed_req(ACT_SETPOINT, 32'sd655360, -32'sd65536, 16'hffff,
                                         1'b1));
        pending_reqs.push_back(fixed_req(ACT_STEP, 32'sd0, 32'sd0, 16'd6553, 1'b1));
        pending_reqs.push_back(fixed_req(ACT_STEP, 32'sd0, 32'sd0, 16'd6553, 1'b1));
        drain();

        // integral clamp and negative vertical cap
        write_reg(REG_INT_H_GAIN, 32'd1 << 20);
        write_reg(REG_INT_V_GAIN, 32'd1 << 20);
        write_reg(REG_POS_V_LIMIT, -32'sd131072);
        drain();
        for (int k = 0; k < 6; k++)
            pending_reqs.push_back(fixed_req(ACT_STEP, -32'sd327680, 32'sd65536, 16'hffff,
                                             k != 4));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_regs(ph < 2 ? ph : 2);
            drain();
            for (int k = 0; k < 200; k++)
                pending_reqs.push_back(rand_req($urandom_range(0, 3) != 0));
            drain();
        end

        if (errors == 0 && accel_expected.size() == 0) begin
            $display("[cascaded_position_velocity_controller_unit] OK");
        end else begin
            $display("[cascaded_position_velocity_controller_unit] ERROR");
        end
        $finish;
    end
endmodule
